// ----- sv/vck_pkg.sv -----
package vck_pkg;

  localparam int MAX_PROCS   = 16;
  localparam int COUNT_WIDTH = 32;

  // Index of a stored entry.
  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

  // Fixed field widths of the ports.
  localparam int PIDX_W     = 6;
  localparam int VALUE_W    = 32;
  localparam int PCOUNT_W   = 7;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int TDATA_W    = ((PIDX_W + VALUE_W + 7) / 8) * 8;
  localparam int PAD_W      = TDATA_W - PIDX_W - VALUE_W;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] COUNT_MAX64 = {64{1'b1}} >> (64 - COUNT_WIDTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_EVENT   = 2'd0,
    CMD_SEND    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RECEIVE = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_INDEX     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT = 1'b1;

  // One classified operation handed from the front to the back.
  typedef struct packed {
    logic                   do_tick;
    logic                   do_merge;
    logic                   do_emit;
    logic                   is_stamp;
    logic [IDX_W-1:0]       index;
    logic [COUNT_WIDTH-1:0] value;
    logic [IDX_W-1:0]       last_index;
  } op_t;

endpackage

// ----- sv/vector_clock_keeper.sv -----
// Channel  Direction  tdata (low bit up)                tuser         tlast
// in_      in         peer_index, peer_value, pad       command       -
// out_     out        entry_index, entry_value, pad     is_stamp      last_entry
// cfg_     in         cfg_index: register, cfg_data: value
//
// Local event and receive words sustain one word per cycle while the update unit
// is not emitting. A send ticks the own entry; a send or read then emits
// process_count entries (clamped to 1..MAX_PROCS), one entry per cycle while the
// output is taken, through the single read port of the clock store. Reset is
// synchronous and clears the whole vector at once. While the unit emits, up to three
// more words are accepted (two in the queue, one in the input stage).
module vector_clock_keeper (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vck_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vck_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vck_pkg::TDATA_W-1:0]       in_tdata,  // peer_index, peer_value
  input  logic [vck_pkg::CMD_W-1:0]         in_tuser,  // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vck_pkg::TDATA_W-1:0]       out_tdata, // entry_index, entry_value
  output logic                              out_tlast,
  output logic                              out_tuser  // is_stamp
);

  logic         f_valid;
  logic         f_ready;
  vck_pkg::op_t f_op;
  logic         b_valid;
  logic         b_ready;
  vck_pkg::op_t b_op;

  vck_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op        (f_op)
  );

  vck_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_op),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_op)
  );

  vck_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (b_valid),
    .op_ready   (b_ready),
    .op         (b_op),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- sv/vck_front.sv -----
module vck_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vck_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vck_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vck_pkg::TDATA_W-1:0]       in_tdata,
  input  logic [vck_pkg::CMD_W-1:0]         in_tuser,
  output logic                              op_valid,
  input  logic                              op_ready,
  output vck_pkg::op_t                      op
);

  localparam logic [vck_pkg::PCOUNT_W-1:0] MAX_CNT =
    vck_pkg::PCOUNT_W'(vck_pkg::MAX_PROCS);

  logic [vck_pkg::PIDX_W-1:0]   own_r;
  logic [vck_pkg::PCOUNT_W-1:0] count_r;
  logic                         hold_vld_r;
  vck_pkg::op_t                 hold_r;
  vck_pkg::op_t                 op_nxt;

  logic [vck_pkg::PCOUNT_W-1:0] n_eff;
  logic [vck_pkg::PIDX_W-1:0]   peer;
  logic [vck_pkg::VALUE_W-1:0]  pval;
  logic [63:0]                  pval_sat;
  logic                         own_ok;
  logic                         peer_ok;
  logic                         peer_own;
  vck_pkg::cmd_t                cmd;

  assign cfg_ready = 1'b1;
  assign in_tready = !hold_vld_r || op_ready;
  assign op_valid  = hold_vld_r;
  assign op        = hold_r;

  assign cmd  = vck_pkg::cmd_t'(in_tuser);
  assign peer = in_tdata[vck_pkg::PIDX_W-1:0];
  assign pval = in_tdata[vck_pkg::PIDX_W +: vck_pkg::VALUE_W];

  always_comb begin
    priority if (count_r == '0) begin
      n_eff = vck_pkg::PCOUNT_W'(1);
    end else if (count_r > MAX_CNT) begin
      n_eff = MAX_CNT;
    end else begin
      n_eff = count_r;
    end
  end

  assign own_ok   = {1'b0, own_r} < n_eff;
  assign peer_ok  = {1'b0, peer} < n_eff;
  assign peer_own = peer == own_r;

  // A received value beyond the counter range is clamped to the maximum.
  assign pval_sat = (64'(pval) > vck_pkg::COUNT_MAX64) ? vck_pkg::COUNT_MAX64 : 64'(pval);

  always_comb begin
    op_nxt            = '0;
    op_nxt.value      = vck_pkg::COUNT_WIDTH'(pval_sat);
    op_nxt.last_index = vck_pkg::IDX_W'(n_eff - vck_pkg::PCOUNT_W'(1));
    unique case (cmd)
      vck_pkg::CMD_EVENT: begin
        op_nxt.do_tick = own_ok;
      end
      vck_pkg::CMD_SEND: begin
        op_nxt.do_tick  = own_ok;
        op_nxt.do_emit  = 1'b1;
        op_nxt.is_stamp = 1'b1;
      end
      vck_pkg::CMD_READ: begin
        op_nxt.do_emit = 1'b1;
      end
      vck_pkg::CMD_RECEIVE: begin
        op_nxt.do_tick  = peer_ok && peer_own;
        op_nxt.do_merge = peer_ok && !peer_own;
      end
      default: begin
        op_nxt.do_tick = 1'b0;
      end
    endcase
    op_nxt.index = op_nxt.do_merge ? vck_pkg::IDX_W'(peer) : vck_pkg::IDX_W'(own_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r      <= '0;
      count_r    <= vck_pkg::PCOUNT_W'(16);
      hold_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          vck_pkg::REG_OWN_INDEX:     own_r   <= cfg_data[vck_pkg::PIDX_W-1:0];
          vck_pkg::REG_PROCESS_COUNT: count_r <= cfg_data[vck_pkg::PCOUNT_W-1:0];
          default:                    own_r   <= own_r;
        endcase
      end
      if (in_tvalid && in_tready) begin
        hold_vld_r <= 1'b1;
      end else if (op_ready) begin
        hold_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_r <= op_nxt;
    end
  end

endmodule

// ----- sv/vck_fifo.sv -----
module vck_fifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  vck_pkg::op_t push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output vck_pkg::op_t pop_data
);

  localparam logic [vck_pkg::QPTR_W-1:0] LAST_PTR =
    vck_pkg::QPTR_W'(vck_pkg::QUEUE_DEPTH - 1);
  localparam logic [vck_pkg::QCNT_W-1:0] FULL_CNT =
    vck_pkg::QCNT_W'(vck_pkg::QUEUE_DEPTH);

  vck_pkg::op_t                slot_r [vck_pkg::QUEUE_DEPTH];
  logic [vck_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [vck_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [vck_pkg::QCNT_W-1:0]  cnt_r;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = cnt_r != FULL_CNT;
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/vck_back.sv -----
module vck_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        op_valid,
  output logic                        op_ready,
  input  vck_pkg::op_t                op,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [vck_pkg::TDATA_W-1:0] out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t                          state_r;
  logic [vck_pkg::COUNT_WIDTH-1:0] entries_r [vck_pkg::MAX_PROCS];
  logic [vck_pkg::IDX_W-1:0]       idx_r;
  logic [vck_pkg::IDX_W-1:0]       last_r;
  logic                            stamp_r;
  logic                            out_vld_r;
  logic [vck_pkg::PIDX_W-1:0]      out_idx_r;
  logic [vck_pkg::VALUE_W-1:0]     out_val_r;
  logic                            out_last_r;
  logic                            out_stamp_r;

  logic [vck_pkg::IDX_W-1:0]       rd_idx;
  logic [vck_pkg::COUNT_WIDTH-1:0] rd_val;
  logic                            slot_free;

  // One read port serves both the update of an entry and the emission sweep.
  assign rd_idx    = (state_r == ST_EMIT) ? idx_r : op.index;
  assign rd_val    = entries_r[rd_idx];
  assign slot_free = !out_vld_r || out_tready;
  assign op_ready  = state_r == ST_IDLE;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{vck_pkg::PAD_W{1'b0}}, out_val_r, out_idx_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      idx_r     <= '0;
      last_r    <= '0;
      stamp_r   <= 1'b0;
      for (int i = 0; i < vck_pkg::MAX_PROCS; i++) begin
        entries_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (out_vld_r && out_tready) begin
            out_vld_r <= 1'b0;
          end
          if (op_valid) begin
            if (op.do_tick && (rd_val != '1)) begin
              entries_r[rd_idx] <= rd_val + 1'b1;
            end
            if (op.do_merge && (op.value > rd_val)) begin
              entries_r[rd_idx] <= op.value;
            end
            if (op.do_emit) begin
              state_r <= ST_EMIT;
              idx_r   <= '0;
              last_r  <= op.last_index;
              stamp_r <= op.is_stamp;
            end
          end
        end
        ST_EMIT: begin
          // A full output register that is not taken keeps its word.
          if (slot_free) begin
            out_vld_r   <= 1'b1;
            out_idx_r   <= vck_pkg::PIDX_W'(idx_r);
            out_val_r   <= vck_pkg::VALUE_W'(rd_val);
            out_last_r  <= idx_r == last_r;
            out_stamp_r <= stamp_r;
            if (idx_r == last_r) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: begin
          state_r   <= ST_IDLE;
          out_vld_r <= 1'b0;
        end
      endcase
    end
  end

endmodule
